>>> src/hs_pkg.sv
// Shared types and constants for the heap_sort block.
package hs_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int WAIT_CYCLES = DEPTH + 1;
   localparam int WAIT_W      = $clog2(WAIT_CYCLES + 1);

   typedef logic signed [VALUE_W-1:0] value_type;

   // One slot of data moving along or held in the cell chain.
   typedef struct packed {
      logic      valid;
      value_type value;
   } link_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_OUT
   } state_type;

endpackage

>>> src/hs_cell.sv
// One cell of the sorting chain: holds one element and forwards the larger value.
module hs_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  hs_pkg::link_type in_link,
   input  hs_pkg::link_type next_link,
   output hs_pkg::link_type held_link,
   output hs_pkg::link_type pass_link
);
   import hs_pkg::*;

   link_type held_ff, held_in;
   link_type pass_ff, pass_in;

   always_comb begin
      held_in = held_ff;
      pass_in = '0;
      if (shift_en) begin
         // Output phase: every cell takes its upper neighbor's element.
         held_in = next_link;
      end else if (in_link.valid) begin
         if (!held_ff.valid) begin
            held_in = in_link;
         end else if ($signed(in_link.value) < $signed(held_ff.value)) begin
            held_in = in_link;
            pass_in = held_ff;
         end else begin
            pass_in = in_link;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff.value <= held_in.value;
      pass_ff.value <= pass_in.value;
      if (reset) begin
         held_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         pass_ff.valid <= pass_in.valid;
      end
   end

   assign held_link = held_ff;
   assign pass_link = pass_ff;

endmodule

>>> src/hs_ctrl.sv
// Sequencer for loading, settling and emitting one set of elements.
module hs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  hs_pkg::value_type req_value,
   input  logic              req_last_item,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_last_result,
   output logic              rsp_dropped,
   output logic              shift_en,
   output hs_pkg::link_type  entry_link
);
   import hs_pkg::*;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic               ovf_ff, ovf_in;
   link_type           entry_ff, entry_in;
   logic               req_accept;
   logic               rsp_accept;
   logic               has_room;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign has_room   = count_ff < COUNT_W'(DEPTH);
   assign shift_en   = rsp_accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_last_item) state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            if (wait_ff == '0) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_accept && count_ff == COUNT_W'(1)) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_LOAD);
      rsp_valid       = (state_ff == ST_OUT);
      rsp_last_result = (count_ff == COUNT_W'(1));
      rsp_dropped     = ovf_ff;
   end

   always_comb begin
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      wait_in        = wait_ff;
      entry_in.valid = req_accept && has_room;
      entry_in.value = req_value;
      if (req_accept) begin
         if (has_room) count_in = count_ff + COUNT_W'(1);
         else          ovf_in   = 1'b1;
         wait_in = WAIT_W'(WAIT_CYCLES);
      end else if (state_ff == ST_SETTLE && wait_ff != '0) begin
         wait_in = wait_ff - WAIT_W'(1);
      end
      if (rsp_accept) begin
         count_in = count_ff - COUNT_W'(1);
         if (count_ff == COUNT_W'(1)) ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.value <= entry_in.value;
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         wait_ff        <= '0;
         ovf_ff         <= 1'b0;
         entry_ff.valid <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         wait_ff        <= wait_in;
         ovf_ff         <= ovf_in;
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry_link = entry_ff;

endmodule

>>> src/heap_sort.sv
// Top level of the heap_sort block: a systolic sorting chain and its sequencer.
//
// This block sorts one set of signed 32-bit values into ascending order. Requests
// are taken one per cycle while the block is loading; each value enters a chain of
// DEPTH cells, where every cell keeps the smaller of what it holds and what
// arrives and hands the larger one to its neighbor on the next cycle, so several
// insertions travel down the chain at once. A request marked last_item closes the
// set: the block then waits while the last insertion wave walks the full chain,
// and afterwards emits the set from the head cell, at most one result per cycle,
// with the whole chain shifting toward the head on each accepted result. Requests
// stay stalled from the marked request until the final result is taken. Values
// beyond DEPTH are discarded, and every result of such a set carries dropped. The
// final result of the set carries last_result; the block then returns to loading.
module heap_sort (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hs_pkg::value_type req_value,
   input  logic              req_last_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hs_pkg::value_type rsp_value_res,
   output logic              rsp_last_result,
   output logic              rsp_dropped
);
   import hs_pkg::*;

   link_type entry_link;
   logic     shift_en;

   // Link i feeds cell i; held[i] is cell i's element, held[DEPTH] is an empty slot.
   link_type chain_link [DEPTH+1];
   link_type held_link  [DEPTH+1];

   hs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_value       (req_value),
      .req_last_item   (req_last_item),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_last_result (rsp_last_result),
      .rsp_dropped     (rsp_dropped),
      .shift_en        (shift_en),
      .entry_link      (entry_link)
   );

   assign chain_link[0]     = entry_link;
   assign held_link[DEPTH]  = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      hs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .in_link   (chain_link[i]),
         .next_link (held_link[i+1]),
         .held_link (held_link[i]),
         .pass_link (chain_link[i+1])
      );
   end

   // The head cell always holds the smallest remaining element.
   assign rsp_value_res = held_link[0].value;

endmodule
